// ===== rtl/core/pclte_pkg.sv =====
// Shared types and constants of the pc/line table encoder.
`timescale 1ns / 1ps

package pclte_pkg;

	localparam int unsigned PC_W        = 64;
	localparam int unsigned LINE_W      = 31;
	localparam int unsigned COUNT_W     = 32;
	localparam int unsigned DELTA_W     = 32;
	localparam int unsigned RUN_MAX     = 127;
	localparam int unsigned MAX_PC_BYTES = 59;
	localparam int unsigned MAX_UNITS   = RUN_MAX * MAX_PC_BYTES;
	localparam int unsigned UNITS_W     = $clog2(MAX_UNITS + 1);
	localparam int unsigned SMALL_DELTA = 64;
	localparam int unsigned LONG_LAST   = 4;

	localparam logic [7:0] RUN_BASE  = 8'd128;
	localparam logic [7:0] PAD_BYTE  = 8'd129;
	localparam logic [7:0] LONG_MARK = 8'd0;
	localparam logic [PC_W-1:0] NEG_PC_UNIT = ~64'd3;

	typedef enum logic [1:0] {
		FUNC_INSN   = 2'd0,
		FUNC_TEXT   = 2'd1,
		FUNC_FINISH = 2'd2,
		FUNC_SPARE  = 2'd3
	} func_t;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PCDIFF = 7'b0000010,
		ST_LNDIFF = 7'b0000100,
		ST_PCUPD  = 7'b0001000,
		ST_PCRUN  = 7'b0010000,
		ST_LINE   = 7'b0100000,
		ST_PAD    = 7'b1000000
	} state_t;

endpackage

// ===== rtl/core/pc_line_table_encoder_core.sv =====
// Top level of the pc/line table encoder: sequencer, shared subtractor and output register.
// A changed-line instruction record steps through the pc difference, line difference and
// pc update states, which share one 64-bit subtractor, then emits its pc run and line bytes;
// a padding finish emits one pad byte, and other requests leave the input free. No request
// is taken while a record is in progress; output stalls hold the sequencer as it emits.
// Reset clears the previous pc, previous line and byte count to zero and empties the output.
`timescale 1ns / 1ps

module pc_line_table_encoder_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start_pc_we,
	input  logic [pclte_pkg::PC_W-1:0]       start_pc,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       func,
	input  logic [pclte_pkg::PC_W-1:0]       code_address,
	input  logic [pclte_pkg::LINE_W-1:0]     line_number,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [7:0]                       out_byte,
	output logic                             last,
	output logic                             error,
	output logic [pclte_pkg::COUNT_W-1:0]    table_bytes
);

	pclte_pkg::state_t state_q;

	logic [pclte_pkg::PC_W-1:0]    prev_pc_q;
	logic [pclte_pkg::LINE_W-1:0]  prev_line_q;
	logic [pclte_pkg::COUNT_W-1:0] byte_count_q;
	logic [pclte_pkg::PC_W-1:0]    pc_q;
	logic [pclte_pkg::LINE_W-1:0]  line_q;
	logic [pclte_pkg::UNITS_W-1:0] units_q;
	logic [pclte_pkg::DELTA_W-1:0] delta_q;
	logic                          big_q;
	logic                          err_q;
	logic [2:0]                    lcnt_q;

	logic                          out_valid_q;
	logic [7:0]                    out_byte_q;
	logic                          last_q;
	logic                          error_q;
	logic [pclte_pkg::COUNT_W-1:0] table_bytes_q;

	logic                          accept;
	logic                          slot_free;
	logic [pclte_pkg::PC_W-1:0]    sub_a;
	logic [pclte_pkg::PC_W-1:0]    sub_b;
	logic [pclte_pkg::PC_W:0]      sub_r;
	logic                          sub_borrow;
	logic [pclte_pkg::PC_W-3:0]    diff_units;
	logic                          units_ovf;
	logic signed [pclte_pkg::DELTA_W-1:0] sdelta;
	logic [6:0]                    run;
	logic                          emit;
	logic [7:0]                    emit_byte;
	logic                          emit_last;
	logic                          emit_err;

	assign in_stall  = (state_q != pclte_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		unique case (state_q)
			pclte_pkg::ST_LNDIFF: begin
				sub_a = {{(pclte_pkg::PC_W - pclte_pkg::LINE_W){1'b0}}, line_q};
				sub_b = {{(pclte_pkg::PC_W - pclte_pkg::LINE_W){1'b0}}, prev_line_q};
			end
			pclte_pkg::ST_PCUPD: begin
				sub_a = pc_q;
				sub_b = pclte_pkg::NEG_PC_UNIT;
			end
			default: begin
				sub_a = pc_q;
				sub_b = prev_pc_q;
			end
		endcase
	end

	assign sub_r      = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_borrow = sub_r[pclte_pkg::PC_W];
	assign diff_units = sub_r[pclte_pkg::PC_W-1:2];
	assign units_ovf  = (diff_units > (pclte_pkg::PC_W-2)'(pclte_pkg::MAX_UNITS));
	assign sdelta     = sub_r[pclte_pkg::DELTA_W-1:0];

	assign run = (units_q >= pclte_pkg::UNITS_W'(pclte_pkg::RUN_MAX)) ?
		7'(pclte_pkg::RUN_MAX) : units_q[6:0];

	always_comb begin
		emit      = 1'b0;
		emit_byte = pclte_pkg::PAD_BYTE;
		emit_last = 1'b0;
		emit_err  = err_q;
		unique case (state_q)
			pclte_pkg::ST_PCRUN: begin
				emit      = slot_free;
				emit_byte = pclte_pkg::RUN_BASE + {1'b0, run};
			end
			pclte_pkg::ST_LINE: begin
				emit = slot_free;
				if (big_q) begin
					unique case (lcnt_q)
						3'd0:    emit_byte = pclte_pkg::LONG_MARK;
						3'd1:    emit_byte = delta_q[31:24];
						3'd2:    emit_byte = delta_q[23:16];
						3'd3:    emit_byte = delta_q[15:8];
						default: emit_byte = delta_q[7:0];
					endcase
					emit_last = (lcnt_q == 3'(pclte_pkg::LONG_LAST));
				end else begin
					if ($signed(delta_q) > 0) begin
						emit_byte = delta_q[7:0];
					end else begin
						emit_byte = 8'(pclte_pkg::SMALL_DELTA) - delta_q[7:0];
					end
					emit_last = 1'b1;
				end
			end
			pclte_pkg::ST_PAD: begin
				emit      = slot_free;
				emit_byte = pclte_pkg::PAD_BYTE;
				emit_last = 1'b1;
				emit_err  = 1'b0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pclte_pkg::ST_IDLE;
			prev_pc_q    <= '0;
			prev_line_q  <= '0;
			byte_count_q <= '0;
		end else begin
			if (start_pc_we) begin
				prev_pc_q <= start_pc;
			end
			if (emit) begin
				byte_count_q <= byte_count_q + 1'b1;
			end
			unique case (state_q)
				pclte_pkg::ST_IDLE: begin
					if (accept) begin
						if (func == pclte_pkg::FUNC_FINISH) begin
							if (byte_count_q[0]) begin
								state_q <= pclte_pkg::ST_PAD;
							end
						end else if (func == pclte_pkg::FUNC_INSN && line_number != prev_line_q) begin
							state_q <= pclte_pkg::ST_PCDIFF;
						end
					end
				end
				pclte_pkg::ST_PCDIFF: begin
					state_q <= pclte_pkg::ST_LNDIFF;
				end
				pclte_pkg::ST_LNDIFF: begin
					prev_line_q <= line_q;
					state_q     <= pclte_pkg::ST_PCUPD;
				end
				pclte_pkg::ST_PCUPD: begin
					prev_pc_q <= sub_r[pclte_pkg::PC_W-1:0];
					state_q   <= (units_q != '0) ? pclte_pkg::ST_PCRUN : pclte_pkg::ST_LINE;
				end
				pclte_pkg::ST_PCRUN: begin
					if (emit && units_q == pclte_pkg::UNITS_W'(run)) begin
						state_q <= pclte_pkg::ST_LINE;
					end
				end
				pclte_pkg::ST_LINE: begin
					if (emit && emit_last) begin
						state_q <= pclte_pkg::ST_IDLE;
					end
				end
				pclte_pkg::ST_PAD: begin
					if (emit) begin
						state_q <= pclte_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pclte_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pc_q   <= code_address;
			line_q <= line_number;
			lcnt_q <= '0;
			err_q  <= 1'b0;
		end
		if (state_q == pclte_pkg::ST_PCDIFF) begin
			if (sub_borrow) begin
				err_q   <= 1'b1;
				units_q <= '0;
			end else if (units_ovf) begin
				err_q   <= 1'b1;
				units_q <= pclte_pkg::UNITS_W'(pclte_pkg::MAX_UNITS);
			end else begin
				units_q <= diff_units[pclte_pkg::UNITS_W-1:0];
			end
		end
		if (state_q == pclte_pkg::ST_LNDIFF) begin
			delta_q <= sdelta;
			big_q   <= (sdelta > $signed(pclte_pkg::DELTA_W'(pclte_pkg::SMALL_DELTA))) ||
				(sdelta < -$signed(pclte_pkg::DELTA_W'(pclte_pkg::SMALL_DELTA)));
		end
		if (emit && state_q == pclte_pkg::ST_PCRUN) begin
			units_q <= units_q - pclte_pkg::UNITS_W'(run);
		end
		if (emit && state_q == pclte_pkg::ST_LINE) begin
			lcnt_q <= lcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q    <= emit_byte;
			last_q        <= emit_last;
			error_q       <= emit_err;
			table_bytes_q <= byte_count_q + 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last        = last_q;
	assign error       = error_q;
	assign table_bytes = table_bytes_q;

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("Sequencer state is not one-hot.");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> slot_free)
		else $error("Byte loaded into a full, stalled output register.");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> byte_count_q == $past(byte_count_q) + 1'b1)
		else $error("Byte count did not follow an emitted byte.");

	a_pad_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pclte_pkg::ST_PAD |-> byte_count_q[0])
		else $error("Padding started on an even table length.");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pclte_pkg::ST_PCRUN |-> units_q != '0)
		else $error("Pc run state entered with no units left.");

endmodule

// ===== verif/pc_line_table_checker.sv =====
// Checker that predicts the pc/line table bytes and compares them with the block's output.
`timescale 1ns / 1ps

module pc_line_table_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start_pc_we,
	input  logic [pclte_pkg::PC_W-1:0]     start_pc,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [1:0]                     func,
	input  logic [pclte_pkg::PC_W-1:0]     code_address,
	input  logic [pclte_pkg::LINE_W-1:0]   line_number,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [7:0]                     out_byte,
	input  logic                           last,
	input  logic                           error,
	input  logic [pclte_pkg::COUNT_W-1:0]  table_bytes,
	output int unsigned                    mismatch_count,
	output int unsigned                    bytes_outstanding
);

	typedef struct packed {
		logic [7:0]                    value;
		logic                          last;
		logic                          error;
		logic [pclte_pkg::COUNT_W-1:0] count;
	} table_byte_t;

	table_byte_t                    expected_bytes[$];
	table_byte_t                    want;
	logic [pclte_pkg::PC_W-1:0]     base_pc;
	logic [pclte_pkg::LINE_W-1:0]   last_line;
	logic [pclte_pkg::COUNT_W-1:0]  emitted;
	int unsigned                    errors = 0;

	assign mismatch_count = errors;

	function automatic void encode_record(input logic [1:0] f,
			input logic [pclte_pkg::PC_W-1:0] pc, input logic [pclte_pkg::LINE_W-1:0] ln);
		logic [7:0]                           seq[$];
		logic [pclte_pkg::PC_W-1:0]           units;
		logic signed [pclte_pkg::DELTA_W-1:0] delta;
		logic                                 err;
		table_byte_t                          entry;
		err = 1'b0;
		if (f == pclte_pkg::FUNC_FINISH) begin
			if (emitted[0])
				seq.push_back(pclte_pkg::PAD_BYTE);
		end else if (f == pclte_pkg::FUNC_INSN && ln != last_line) begin
			if (pc < base_pc) begin
				err = 1'b1;
			end else begin
				units = (pc - base_pc) >> 2;
				while (units != 0 && !err) begin
					if (seq.size() == pclte_pkg::MAX_PC_BYTES) begin
						err = 1'b1;
					end else if (units > pclte_pkg::RUN_MAX) begin
						seq.push_back(pclte_pkg::RUN_BASE + 8'(pclte_pkg::RUN_MAX));
						units = units - pclte_pkg::RUN_MAX;
					end else begin
						seq.push_back(pclte_pkg::RUN_BASE + 8'(units));
						units = '0;
					end
				end
			end
			delta = $signed({1'b0, ln}) - $signed({1'b0, last_line});
			if (delta > 64 || delta < -64) begin
				seq.push_back(pclte_pkg::LONG_MARK);
				seq.push_back(delta[31:24]);
				seq.push_back(delta[23:16]);
				seq.push_back(delta[15:8]);
				seq.push_back(delta[7:0]);
			end else if (delta > 0) begin
				seq.push_back(8'(delta));
			end else begin
				seq.push_back(8'(64 - delta));
			end
			last_line = ln;
			base_pc = pc + 64'd4;
		end
		foreach (seq[i]) begin
			emitted = emitted + 1'b1;
			entry.value = seq[i];
			entry.last = (i == seq.size() - 1);
			entry.error = err;
			entry.count = emitted;
			expected_bytes.push_back(entry);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_bytes.delete();
			base_pc = '0;
			last_line = '0;
			emitted = '0;
			bytes_outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("table byte %0d arrived with no request waiting for it", out_byte);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.value) begin
						$error("out_byte: expected %0d, got %0d", want.value, out_byte);
						errors++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						errors++;
					end
					if (error !== want.error) begin
						$error("error: expected %0d, got %0d", want.error, error);
						errors++;
					end
					if (table_bytes !== want.count) begin
						$error("table_bytes: expected %0d, got %0d", want.count, table_bytes);
						errors++;
					end
				end
			end
			if (start_pc_we)
				base_pc = start_pc;
			if (in_valid && !in_stall)
				encode_record(func, code_address, line_number);
			bytes_outstanding <= expected_bytes.size();
		end
	end

endmodule

// ===== verif/pc_line_table_encoder_core_tb.sv =====
// Testbench top of the pc/line table encoder: stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps

module pc_line_table_encoder_core_tb;

	localparam int unsigned HOLD_CYCLES    = 240;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start_pc_we = 1'b0;
	logic [pclte_pkg::PC_W-1:0]     start_pc = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	pclte_pkg::func_t               func = pclte_pkg::FUNC_INSN;
	logic [pclte_pkg::PC_W-1:0]     code_address = '0;
	logic [pclte_pkg::LINE_W-1:0]   line_number = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [7:0]                     out_byte;
	logic                           last;
	logic                           error;
	logic [pclte_pkg::COUNT_W-1:0]  table_bytes;

	int unsigned                    mismatch_count;
	int unsigned                    bytes_outstanding;

	bit                             tx_idle = 1'b1;
	bit                             rx_idle = 1'b1;
	int unsigned                    holds_requested = 0;
	logic [pclte_pkg::PC_W-1:0]     next_pc = '0;
	logic [pclte_pkg::LINE_W-1:0]   cur_line = '0;

	always #6 clk = ~clk;

	pc_line_table_encoder_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_pc_we  (start_pc_we),
		.start_pc     (start_pc),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.code_address (code_address),
		.line_number  (line_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last         (last),
		.error        (error),
		.table_bytes  (table_bytes)
	);

	pc_line_table_checker i_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.start_pc_we       (start_pc_we),
		.start_pc          (start_pc),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.func              (func),
		.code_address      (code_address),
		.line_number       (line_number),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.out_byte          (out_byte),
		.last              (last),
		.error             (error),
		.table_bytes       (table_bytes),
		.mismatch_count    (mismatch_count),
		.bytes_outstanding (bytes_outstanding)
	);

	task automatic send_record(input pclte_pkg::func_t f, input logic [pclte_pkg::PC_W-1:0] pc,
			input logic [pclte_pkg::LINE_W-1:0] ln);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 16) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		code_address <= pc;
		line_number <= ln;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_insn(input logic [pclte_pkg::PC_W-1:0] pc,
			input logic [pclte_pkg::LINE_W-1:0] ln);
		send_record(pclte_pkg::FUNC_INSN, pc, ln);
		if (ln != cur_line) begin
			next_pc = pc + 64'd4;
			cur_line = ln;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (bytes_outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_start_pc(input logic [pclte_pkg::PC_W-1:0] value);
		drain();
		start_pc_we <= 1'b1;
		start_pc <= value;
		@(posedge clk);
		start_pc_we <= 1'b0;
		next_pc = value;
	endtask

	task automatic send_random_record();
		int unsigned                  pick;
		logic [pclte_pkg::PC_W-1:0]   pc;
		logic [pclte_pkg::LINE_W-1:0] ln;
		pick = $urandom_range(0, 99);
		pc = {$urandom, $urandom};
		ln = pclte_pkg::LINE_W'($urandom);
		if (pick < 5) begin
			send_record(pclte_pkg::FUNC_TEXT, pc, ln);
		end else if (pick < 8) begin
			send_record(pclte_pkg::FUNC_SPARE, pc, ln);
		end else if (pick < 15) begin
			send_record(pclte_pkg::FUNC_FINISH, pc, ln);
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				pc = next_pc + 64'($urandom_range(0, 160));
			else if (pick < 77)
				pc = next_pc + 64'($urandom_range(508, 4000));
			else if (pick < 85)
				pc = next_pc;
			else if (pick < 92)
				pc = next_pc - 64'($urandom_range(1, 64));
			else if (pick < 96)
				pc = next_pc + 64'($urandom_range(4 * pclte_pkg::MAX_UNITS - 12,
					4 * pclte_pkg::MAX_UNITS + 28));
			pick = $urandom_range(0, 99);
			if (pick < 15)
				ln = cur_line;
			else if (pick < 75)
				ln = cur_line + pclte_pkg::LINE_W'($urandom_range(0, 128))
					- pclte_pkg::LINE_W'(64);
			else if (pick < 90)
				ln = $urandom_range(0, 1)
					? cur_line + pclte_pkg::LINE_W'($urandom_range(65, 1000))
					: cur_line - pclte_pkg::LINE_W'($urandom_range(65, 1000));
			send_insn(pc, ln);
		end
	endtask

	initial begin : receiver
		int unsigned holds_served;
		int unsigned wait_cycles;
		holds_served = 0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (holds_served != holds_requested) begin
				wait_cycles = HOLD_CYCLES;
				holds_served++;
			end else begin
				wait_cycles = rx_idle ? $urandom_range(0, 16) : 0;
			end
			if (wait_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (wait_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL pc_line_table_encoder_core");
		$finish;
	end

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_start_pc(64'h1000);
		send_insn(64'h1000, 31'd1);
		send_record(pclte_pkg::FUNC_FINISH, '0, '0);
		send_record(pclte_pkg::FUNC_FINISH, '0, '0);
		send_insn(64'h2000, 31'd1);
		send_record(pclte_pkg::FUNC_TEXT, {$urandom, $urandom}, 31'd7);
		send_record(pclte_pkg::FUNC_SPARE, {$urandom, $urandom}, 31'd9);
		send_insn(next_pc + 64'(4 * pclte_pkg::RUN_MAX), 31'd65);
		send_insn(next_pc + 64'(4 * pclte_pkg::RUN_MAX + 4), 31'd1);
		send_insn(next_pc + 64'd3, 31'd0);
		send_insn(next_pc - 64'd4, 31'd65);
		send_insn(next_pc + 64'(4 * pclte_pkg::MAX_UNITS), 31'd0);
		send_insn(next_pc + 64'(4 * pclte_pkg::MAX_UNITS + 4), '1);
		send_insn('1, 31'd0);
		send_insn('0, 31'd64);
		send_record(pclte_pkg::FUNC_FINISH, '0, '0);
		send_insn(next_pc, 31'd0);
		send_insn(next_pc + 64'd8, 31'h4000_0000);
		send_record(pclte_pkg::FUNC_FINISH, '1, '1);
		send_record(pclte_pkg::FUNC_FINISH, '1, '1);

		load_start_pc('0);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (80) send_random_record();

		load_start_pc('1);
		tx_idle = 1'b1;
		rx_idle = 1'b0;
		repeat (80) send_random_record();

		load_start_pc({$urandom, $urandom});
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		holds_requested++;
		repeat (14) send_insn(next_pc + 64'd1200, cur_line ^ 31'h1000);
		drain();
		tx_idle = 1'b1;
		repeat (80) send_random_record();

		load_start_pc({$urandom, $urandom});
		tx_idle = 1'b0;
		rx_idle = 1'b1;
		repeat (80) send_random_record();

		drain();
		if (mismatch_count == 0)
			$display("PASS pc_line_table_encoder_core");
		else
			$display("FAIL pc_line_table_encoder_core");
		$finish;
	end

endmodule
